### sv/pidfa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the filtered PID block.
// No dependencies; used by the top level.
package pidfa_pkg;

   // Default data width (Q8.8 samples) and fixed gain scaling
   localparam int DATA_WIDTH     = 16;
   localparam int GAIN_FRAC_BITS = 16;

   // Error filter weight: Q1.16, one is 2^16
   localparam int ALPHA_FRAC  = 16;
   localparam int ALPHA_WIDTH = 17;
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = 17'd65536;

   // Register widths
   localparam int KP_WIDTH    = 24;
   localparam int KI_WIDTH    = 24;
   localparam int KD_WIDTH    = 32;
   localparam int LIMIT_WIDTH = 15;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register reset values
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = ALPHA_ONE;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd32767;

   // Arithmetic widths: state and terms are 32 bits, multiplier is 32 x 33
   localparam int TERM_WIDTH = 32;
   localparam int MUL_A_WIDTH = 32;
   localparam int MUL_B_WIDTH = 33;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int WIDE_WIDTH  = PROD_WIDTH + 1;

   localparam logic signed [WIDE_WIDTH-1:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [WIDE_WIDTH-1:0] SAT_MIN = -66'sd2147483648;

   // Function codes of an input item
   localparam logic FUNC_COMPUTE = 1'b0;
   localparam logic FUNC_CLEAR   = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KP         = 3'd0,
      CSR_KI_DT      = 3'd1,
      CSR_KD_OVER_DT = 3'd2,
      CSR_ALPHA      = 3'd3,
      CSR_LIMIT      = 3'd4
   } csr_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT_A,
      ST_FILT_B,
      ST_FILT_C,
      ST_FILT_D,
      ST_PROP,
      ST_INTEG,
      ST_DERIV,
      ST_SUM_I,
      ST_SUM_D,
      ST_OUT
   } state_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [TERM_WIDTH-1:0] sat32(
      input logic signed [WIDE_WIDTH-1:0] v
   );
      logic signed [TERM_WIDTH-1:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fff_ffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[TERM_WIDTH-1:0];
      end
      return r;
   endfunction

   // Round to nearest (ties up) while dropping sh fraction bits, then saturate
   function automatic logic signed [TERM_WIDTH-1:0] rnd_sat32(
      input logic signed [WIDE_WIDTH-1:0] v,
      input int unsigned                  sh
   );
      logic signed [WIDE_WIDTH-1:0] t;
      t = (v + (66'sd1 <<< (sh - 1))) >>> sh;
      return sat32(t);
   endfunction

endpackage

### sv/pidfa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
// Standalone; the top level takes the sink of one and the source of the other.
interface pidfa_req_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic signed [DATA_WIDTH-1:0] reference;
   logic signed [DATA_WIDTH-1:0] feedback;

   modport source (output valid, output func, output reference, output feedback,
                   input ready);
   modport sink   (input valid, input func, input reference, input feedback,
                   output ready);
endinterface

interface pidfa_rsp_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] control_output;
   logic                         clamped;

   modport source (output valid, output control_output, output clamped, input ready);
   modport sink   (input valid, input control_output, input clamped, output ready);
endinterface

### sv/pid_filtered_antiwindup.sv
`timescale 1ns / 1ps
// PID controller with low-pass filtered derivative and anti-windup clamp.
// Depends on pidfa_pkg and the channel interfaces in pidfa_if.sv.
//
// One request item per control tick. A clear item (func 1) zeroes the integral,
// filtered error and previous error in the cycle it is taken and gives no
// response. A compute item (func 0) runs through a sequencer that feeds one
// shared 32 x 33 signed multiplier five times (two filter products, then the
// proportional, integral and derivative gains) followed by a chain of
// saturating adds; the response is loaded into the output register in the
// final step, and request ready returns only after it. The response register
// decouples the two sides: a new item is taken while the last response waits,
// and the sequencer only holds in its final step if the previous response is
// still not taken. Gain and limit registers are written through the csr port;
// the user must write them only while idle, as the block does not enforce it.
module pid_filtered_antiwindup #(
   parameter int DATA_WIDTH = pidfa_pkg::DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pidfa_req_if.sink                             req,
   pidfa_rsp_if.source                           rsp,
   input  logic                                  csr_we,
   input  logic [pidfa_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pidfa_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int EW = DATA_WIDTH + 1;   // error width
   localparam int TW = pidfa_pkg::TERM_WIDTH;
   localparam int AW = pidfa_pkg::MUL_A_WIDTH;
   localparam int BW = pidfa_pkg::MUL_B_WIDTH;
   localparam int PW = pidfa_pkg::PROD_WIDTH;
   localparam int WW = pidfa_pkg::WIDE_WIDTH;

   // Configuration registers
   logic signed [pidfa_pkg::KP_WIDTH-1:0]  kp_ff;
   logic signed [pidfa_pkg::KI_WIDTH-1:0]  ki_ff;
   logic signed [pidfa_pkg::KD_WIDTH-1:0]  kd_ff;
   logic [pidfa_pkg::ALPHA_WIDTH-1:0]      alpha_ff;
   logic [pidfa_pkg::LIMIT_WIDTH-1:0]      limit_ff;

   // Controller state
   logic signed [TW-1:0] integral_ff, integral_in;
   logic signed [TW-1:0] fe_ff, fe_in;
   logic signed [EW-1:0] prev_ff, prev_in;

   // Sequencer and working registers
   pidfa_pkg::state_type state_ff, state_in;
   logic signed [DATA_WIDTH-1:0] ref_ff, ref_in;
   logic signed [EW-1:0]         err_ff, err_in;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [WW-1:0]         acc_ff, acc_in;
   logic signed [TW-1:0]         fe_new_ff, fe_new_in;
   logic signed [TW-1:0]         deriv_ff, deriv_in;
   logic signed [TW-1:0]         term_ff, term_in;
   logic signed [TW-1:0]         integ_ff, integ_in;
   logic signed [TW-1:0]         sum_ff, sum_in;

   // Response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_output_ff, rsp_output_in;
   logic                         rsp_clamped_ff, rsp_clamped_in;

   // Combinational helpers
   logic                                accept;
   logic                                rsp_free;
   logic                                clip;
   logic [pidfa_pkg::ALPHA_WIDTH-1:0]   alpha_eff;
   logic signed [AW-1:0]                mul_a;
   logic signed [BW-1:0]                mul_b;
   logic signed [TW:0]                  lim_pos;
   logic signed [TW:0]                  lim_neg;
   logic signed [TW-1:0]                clamped_sum;

   assign req.ready         = (state_ff == pidfa_pkg::ST_IDLE);
   assign accept            = req.valid && req.ready;
   assign rsp_free          = !rsp_valid_ff || rsp.ready;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.control_output = rsp_output_ff;
   assign rsp.clamped       = rsp_clamped_ff;

   // Alpha above one acts as one
   assign alpha_eff = (alpha_ff > pidfa_pkg::ALPHA_ONE) ? pidfa_pkg::ALPHA_ONE : alpha_ff;

   // Output clamp against +/- limit
   assign lim_pos = signed'((TW + 1)'(limit_ff));
   assign lim_neg = -lim_pos;
   always_comb begin
      clip        = 1'b1;
      clamped_sum = sum_ff;
      if ((TW + 1)'(sum_ff) > lim_pos) begin
         clamped_sum = lim_pos[TW-1:0];
      end else if ((TW + 1)'(sum_ff) < lim_neg) begin
         clamped_sum = lim_neg[TW-1:0];
      end else begin
         clip = 1'b0;
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         pidfa_pkg::ST_FILT_A: begin
            mul_a = signed'(AW'(alpha_eff));
            mul_b = BW'(err_ff);
         end
         pidfa_pkg::ST_FILT_B: begin
            mul_a = signed'(AW'(pidfa_pkg::ALPHA_ONE - alpha_eff));
            mul_b = BW'(fe_ff);
         end
         pidfa_pkg::ST_FILT_D: begin
            mul_a = AW'(kp_ff);
            mul_b = BW'(err_ff);
         end
         pidfa_pkg::ST_PROP: begin
            mul_a = AW'(ki_ff);
            mul_b = BW'(prev_ff);
         end
         pidfa_pkg::ST_INTEG: begin
            mul_a = AW'(kd_ff);
            mul_b = BW'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      ref_in         = ref_ff;
      err_in         = err_ff;
      acc_in         = acc_ff;
      fe_new_in      = fe_new_ff;
      deriv_in       = deriv_ff;
      term_in        = term_ff;
      integ_in       = integ_ff;
      sum_in         = sum_ff;
      integral_in    = integral_ff;
      fe_in          = fe_ff;
      prev_in        = prev_ff;
      rsp_output_in  = rsp_output_ff;
      rsp_clamped_in = rsp_clamped_ff;
      rsp_valid_in   = rsp.ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         pidfa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req.func == pidfa_pkg::FUNC_CLEAR) begin
                  integral_in = '0;
                  fe_in       = '0;
                  prev_in     = '0;
               end else begin
                  ref_in   = req.reference;
                  err_in   = EW'(req.reference) - EW'(req.feedback);
                  state_in = pidfa_pkg::ST_FILT_A;
               end
            end
         end
         pidfa_pkg::ST_FILT_A: begin
            state_in = pidfa_pkg::ST_FILT_B;
         end
         pidfa_pkg::ST_FILT_B: begin
            acc_in   = WW'(prod_ff);
            state_in = pidfa_pkg::ST_FILT_C;
         end
         pidfa_pkg::ST_FILT_C: begin
            acc_in   = acc_ff + WW'(prod_ff);
            state_in = pidfa_pkg::ST_FILT_D;
         end
         pidfa_pkg::ST_FILT_D: begin
            fe_new_in = pidfa_pkg::rnd_sat32(acc_ff, pidfa_pkg::ALPHA_FRAC);
            state_in  = pidfa_pkg::ST_PROP;
         end
         pidfa_pkg::ST_PROP: begin
            // derivative of the filtered error; proportional term
            deriv_in = pidfa_pkg::sat32(WW'(fe_new_ff) - WW'(fe_ff));
            term_in  = pidfa_pkg::rnd_sat32(WW'(prod_ff), pidfa_pkg::GAIN_FRAC_BITS);
            state_in = pidfa_pkg::ST_INTEG;
         end
         pidfa_pkg::ST_INTEG: begin
            sum_in   = pidfa_pkg::sat32(WW'(ref_ff) + WW'(term_ff));
            term_in  = pidfa_pkg::rnd_sat32(WW'(prod_ff), pidfa_pkg::GAIN_FRAC_BITS);
            state_in = pidfa_pkg::ST_DERIV;
         end
         pidfa_pkg::ST_DERIV: begin
            integ_in = pidfa_pkg::sat32(WW'(integral_ff) + WW'(term_ff));
            term_in  = pidfa_pkg::rnd_sat32(WW'(prod_ff), pidfa_pkg::GAIN_FRAC_BITS);
            state_in = pidfa_pkg::ST_SUM_I;
         end
         pidfa_pkg::ST_SUM_I: begin
            sum_in   = pidfa_pkg::sat32(WW'(sum_ff) + WW'(integ_ff));
            state_in = pidfa_pkg::ST_SUM_D;
         end
         pidfa_pkg::ST_SUM_D: begin
            sum_in   = pidfa_pkg::sat32(WW'(sum_ff) + WW'(term_ff));
            state_in = pidfa_pkg::ST_OUT;
         end
         pidfa_pkg::ST_OUT: begin
            // clamp, commit state and load the response once the slot is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_output_in  = clamped_sum[DATA_WIDTH-1:0];
               rsp_clamped_in = clip;
               if (!clip) begin
                  integral_in = integ_ff;
               end
               fe_in    = fe_new_ff;
               prev_in  = err_ff;
               state_in = pidfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pidfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidfa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         fe_ff        <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         fe_ff        <= fe_in;
         prev_ff      <= prev_in;
      end
   end

   // Working registers, no reset
   always_ff @(posedge clock) begin
      ref_ff         <= ref_in;
      err_ff         <= err_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      fe_new_ff      <= fe_new_in;
      deriv_ff       <= deriv_in;
      term_ff        <= term_in;
      integ_ff       <= integ_in;
      sum_ff         <= sum_in;
      rsp_output_ff  <= rsp_output_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   // Configuration register writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= '0;
         ki_ff    <= '0;
         kd_ff    <= '0;
         alpha_ff <= pidfa_pkg::ALPHA_RESET;
         limit_ff <= pidfa_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (pidfa_pkg::csr_index_type'(csr_index))
            pidfa_pkg::CSR_KP:         kp_ff    <= csr_wdata[pidfa_pkg::KP_WIDTH-1:0];
            pidfa_pkg::CSR_KI_DT:      ki_ff    <= csr_wdata[pidfa_pkg::KI_WIDTH-1:0];
            pidfa_pkg::CSR_KD_OVER_DT: kd_ff    <= csr_wdata[pidfa_pkg::KD_WIDTH-1:0];
            pidfa_pkg::CSR_ALPHA:      alpha_ff <= csr_wdata[pidfa_pkg::ALPHA_WIDTH-1:0];
            pidfa_pkg::CSR_LIMIT:      limit_ff <= csr_wdata[pidfa_pkg::LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // A response only appears out of the final sequencer step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pidfa_pkg::ST_OUT)
      else $error("response raised outside final step");

   // Anti-windup: a clamped tick leaves the integral untouched
   a_windup_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pidfa_pkg::ST_OUT && rsp_free && clip) |=> $stable(integral_ff))
      else $error("integral changed on a clamped tick");

   // Previous error moves only on a committed tick or a clear item
   a_prev_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(prev_ff) |-> ($past(state_ff) == pidfa_pkg::ST_OUT
                             || $past(accept) || $past(reset)))
      else $error("previous error changed outside commit");

   // The sequencer never holds the request side open mid-computation
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func == pidfa_pkg::FUNC_COMPUTE) |=> !req.ready)
      else $error("ready while a compute item is in flight");
`endif

endmodule
